// ===== hw/rtl/rsp_pkg.sv =====
// rsp_pkg: shared constants and the gf(256) multiply for the parity encoder
// no dependencies
`default_nettype none

package rsp_pkg;

  localparam logic [7:0] GF_POLY_LOW = 8'h1D;
  localparam logic [7:0] GF_ALPHA    = 8'h02;
  localparam int unsigned QUEUE_DEPTH = 2;

  // gf(256) multiply, field polynomial 0x11d
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'd0;
    for (int k = 7; k >= 0; k--) begin
      acc = {acc[6:0], 1'b0} ^ (acc[7] ? GF_POLY_LOW : 8'd0);
      acc = acc ^ (b[k] ? a : 8'd0);
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/reed_solomon_parity_encoder.sv =====
// reed_solomon_parity_encoder: systematic rs(gf256, 0x11d) parity generator, top level
// depends on rsp_pkg, rsp_front, rsp_fifo, rsp_back
//
// input stream: one data byte per request on s_tdata, s_tlast marks the last
// byte of a block. output stream: every data byte is echoed (m_tuser low),
// and after the last byte of a block the ECC_LEN parity bytes follow,
// highest-degree term first, with m_tuser high and m_tlast on the final one.
// the front updates the division register in the cycle a byte is accepted,
// through constant gf multipliers and xor trees, so one byte per cycle is
// taken while the queue has space. a QUEUE_DEPTH-entry queue carries each byte and,
// on a block end, the finished parity to the back, which owns the output register.
// each byte passes through the queue and then the back's output register.
// throughput: one output per cycle while the receiver is ready; a block of n bytes
// yields n + ECC_LEN output bytes, the parity burst being set by the single output port.
// reset clears the division register, the queue's pointers and count, and the back's m_tvalid and burst counter.
// when the receiver stalls, the output holds, the queue fills and s_tready
// drops until space frees up.
`default_nettype none

module reed_solomon_parity_encoder #(
  parameter int ECC_LEN = 18
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // data_byte
  input  wire logic       s_tlast,   // block_end
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // out_byte
  output logic            m_tuser,   // is_parity
  output logic            m_tlast    // burst_end
);
  import rsp_pkg::*;

  localparam int EW = ECC_LEN * 8 + 9;

  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;
  logic [EW-1:0] q_wdata;
  logic [EW-1:0] q_rdata;

  rsp_front #(.ECC_LEN(ECC_LEN)) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  rsp_fifo #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  rsp_back #(.ECC_LEN(ECC_LEN)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_rdata  (q_rdata),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/rsp_front.sv =====
// rsp_front: accepts data bytes and runs the rs division register
// depends on rsp_pkg; feeds requests into rsp_fifo
`default_nettype none

module rsp_front #(
  parameter int ECC_LEN = 18
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [7:0]             s_tdata,   // data_byte
  input  wire logic                   s_tlast,   // block_end
  input  wire logic                   q_full,
  output logic                        q_push,
  output logic [ECC_LEN*8+8:0]        q_wdata    // data_byte, block_end, parity bytes
);
  import rsp_pkg::*;

  localparam int PW = ECC_LEN * 8;

  // generator coefficients, lowest index in the lowest byte
  function automatic logic [PW-1:0] gen_poly();
    logic [PW-1:0] g;
    logic [7:0]    root;
    g = '0;
    g[(ECC_LEN-1)*8 +: 8] = 8'd1;
    root = 8'd1;
    for (int i = 0; i < ECC_LEN; i++) begin
      for (int j = 0; j < ECC_LEN; j++) begin
        g[j*8 +: 8] = gf_mul(g[j*8 +: 8], root);
        if (j + 1 < ECC_LEN) begin
          g[j*8 +: 8] = g[j*8 +: 8] ^ g[(j+1)*8 +: 8];
        end
      end
      root = gf_mul(root, GF_ALPHA);
    end
    return g;
  endfunction

  localparam logic [PW-1:0] GEN = gen_poly();

  logic [PW-1:0] par;
  logic [PW-1:0] par_next;
  logic [7:0]    factor;

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && s_tready;
  assign factor   = s_tdata ^ par[7:0];

  always_comb begin
    for (int i = 0; i < ECC_LEN; i++) begin
      if (i + 1 < ECC_LEN) begin
        par_next[i*8 +: 8] = par[(i+1)*8 +: 8] ^ gf_mul(GEN[i*8 +: 8], factor);
      end else begin
        par_next[i*8 +: 8] = gf_mul(GEN[i*8 +: 8], factor);
      end
    end
  end

  assign q_wdata = {par_next, s_tlast, s_tdata};

  always_ff @(posedge clk) begin
    if (rst) begin
      par <= '0;
    end else if (q_push) begin
      par <= s_tlast ? '0 : par_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rsp_fifo.sv =====
// rsp_fifo: short request queue between front and back
// no dependencies
`default_nettype none

module rsp_fifo #(
  parameter int WIDTH = 153,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rsp_back.sv =====
// rsp_back: drains requests, echoes bytes and plays out the parity burst
// consumes requests from rsp_fifo
`default_nettype none

module rsp_back #(
  parameter int ECC_LEN = 18
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_empty,
  input  wire logic [ECC_LEN*8+8:0] q_rdata,  // data_byte, block_end, parity bytes
  output logic                     q_pop,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [7:0]               m_tdata,   // out_byte
  output logic                     m_tuser,   // is_parity
  output logic                     m_tlast    // burst_end
);

  localparam int PW = ECC_LEN * 8;
  localparam int CW = $clog2(ECC_LEN + 1);

  logic [PW-1:0] par;
  logic [CW-1:0] cnt;
  logic          adv;

  assign adv   = !m_tvalid || m_tready;
  assign q_pop = adv && (cnt == '0) && !q_empty;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (cnt != '0) begin
        m_tdata <= par[7:0];
        m_tuser <= 1'b1;
        m_tlast <= (cnt == CW'(1));
        par     <= {8'd0, par[PW-1:8]};
      end else if (!q_empty) begin
        m_tdata <= q_rdata[7:0];
        m_tuser <= 1'b0;
        m_tlast <= 1'b0;
        par     <= q_rdata[PW+8:9];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      cnt      <= '0;
    end else if (adv) begin
      if (cnt != '0) begin
        m_tvalid <= 1'b1;
        cnt      <= cnt - 1'b1;
      end else if (!q_empty) begin
        m_tvalid <= 1'b1;
        cnt      <= q_rdata[8] ? CW'(ECC_LEN) : '0;
      end else begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
